// ===== src/prf_pkg.sv =====
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types and constants of the packet rule filter: rule record,
// packet header record, protocol numbers and deny bit codes.
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned PortW    = 16;
  localparam int unsigned ProtoW   = 8;
  localparam int unsigned DenyW    = 2;
  localparam int unsigned InDataW  = 176;
  localparam int unsigned OutDataW = 8;

  localparam logic [ProtoW-1:0] PROTO_TCP = 8'd6;
  localparam logic [ProtoW-1:0] PROTO_UDP = 8'd17;

  localparam logic [DenyW-1:0] DENY_NONE = 2'b00;
  localparam logic [DenyW-1:0] DENY_TCP  = 2'b01;
  localparam logic [DenyW-1:0] DENY_UDP  = 2'b10;

  typedef enum logic {
    ACT_INSERT   = 1'b0,
    ACT_CLASSIFY = 1'b1
  } action_e;

  typedef struct packed {
    logic [DenyW-1:0] deny_bits;
    logic [PortW-1:0] dst_l4port;
    logic [PortW-1:0] src_l4port;
    logic [AddrW-1:0] dst_netmask;
    logic [AddrW-1:0] dst_address;
    logic [AddrW-1:0] src_netmask;
    logic [AddrW-1:0] src_address;
  } rule_t;

  typedef struct packed {
    logic [DenyW-1:0] deny_sel;
    logic [PortW-1:0] dst_l4port;
    logic [PortW-1:0] src_l4port;
    logic [AddrW-1:0] dst_address;
    logic [AddrW-1:0] src_address;
  } pkt_t;

endpackage

// ===== src/prf_rule_mem.sv =====
// ----------------------------------------------------------------------------
// prf_rule_mem
// Rule table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prf_rule_mem #(
  parameter int unsigned Slots = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_idx_i,
  input  prf_pkg::rule_t    wr_data_i,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_idx_i,
  output prf_pkg::rule_t    rd_data_o
);
  import prf_pkg::*;

  rule_t mem_q [Slots];
  rule_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/prf_match.sv =====
// ----------------------------------------------------------------------------
// prf_match
// Rule comparator: checks one stored rule against the held packet header.
// ----------------------------------------------------------------------------
module prf_match (
  input  prf_pkg::rule_t rule_i,
  input  prf_pkg::pkt_t  pkt_i,
  output logic           hit_o
);
  import prf_pkg::*;

  logic deny_ok;
  logic src_ok;
  logic dst_ok;
  logic sport_ok;
  logic dport_ok;

  always_comb begin
    deny_ok  = (rule_i.deny_bits & pkt_i.deny_sel) != DENY_NONE;
    src_ok   = (pkt_i.src_address & rule_i.src_netmask) == rule_i.src_address;
    dst_ok   = (pkt_i.dst_address & rule_i.dst_netmask) == rule_i.dst_address;
    sport_ok = (rule_i.src_l4port == '0) || (rule_i.src_l4port == pkt_i.src_l4port);
    dport_ok = (rule_i.dst_l4port == '0) || (rule_i.dst_l4port == pkt_i.dst_l4port);
    hit_o    = deny_ok && src_ok && dst_ok && sport_ok && dport_ok;
  end

endmodule

// ===== src/packet_rule_filter_core.sv =====
// ----------------------------------------------------------------------------
// packet_rule_filter_core
// Masked five-tuple deny-rule packet filter with a rule table in memory.
// ----------------------------------------------------------------------------
// One request is handled at a time. An insert stores the rule in the next free
// slot in the cycle it is accepted, or is rejected if the table is full; its
// response goes from the done state into the output register once that is free.
// A TCP or UDP classify reads the stored rules one per cycle through the single
// read port of the rule memory; other protocols, and any classify while the
// table is empty, answer like an insert. A new request is accepted while the
// previous response still waits in the output register.
module packet_rule_filter_core #(
  parameter int unsigned RULE_SLOTS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // ip_protocol, source_address, dest_address, source_port, dest_port,
  // source_mask, dest_mask, deny_kind, zero fill
  input  logic [prf_pkg::InDataW-1:0]     s_axis_tdata,
  // action
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // verdict, insert_rejected, zero fill
  output logic [prf_pkg::OutDataW-1:0]    m_axis_tdata
);
  import prf_pkg::*;

  localparam int unsigned IdxW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(RULE_SLOTS + 1);
  localparam logic [CntW-1:0] SlotsC = CntW'(RULE_SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   rule_count_q, rule_count_d;
  logic [CntW-1:0]   iss_q, iss_d;
  logic              rd_vld_q, rd_vld_d;
  logic              hit_q, hit_d;
  logic              verdict_q, verdict_d;
  logic              rej_q, rej_d;
  logic              out_vld_q, out_vld_d;
  logic              out_verdict_q, out_verdict_d;
  logic              out_rej_q, out_rej_d;
  pkt_t              pkt_q, pkt_d;

  logic              in_acc;
  logic              out_free;
  action_e           act;
  logic [ProtoW-1:0] in_proto;
  logic [DenyW-1:0]  in_sel;
  rule_t             wr_rule;
  logic              wr_en;
  logic              rd_en;
  rule_t             rd_rule;
  logic              rule_hit;

  assign act      = action_e'(s_axis_tuser);
  assign in_proto = s_axis_tdata[7:0];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    priority if (in_proto == PROTO_TCP) begin
      in_sel = DENY_TCP;
    end else if (in_proto == PROTO_UDP) begin
      in_sel = DENY_UDP;
    end else begin
      in_sel = DENY_NONE;
    end
  end

  always_comb begin
    wr_rule.src_address = s_axis_tdata[39:8];
    wr_rule.dst_address = s_axis_tdata[71:40];
    wr_rule.src_l4port  = s_axis_tdata[87:72];
    wr_rule.dst_l4port  = s_axis_tdata[103:88];
    wr_rule.src_netmask = s_axis_tdata[135:104];
    wr_rule.dst_netmask = s_axis_tdata[167:136];
    wr_rule.deny_bits   = s_axis_tdata[169:168];
  end

  assign wr_en = in_acc && (act == ACT_INSERT) && (rule_count_q < SlotsC);
  assign rd_en = (state_q == ST_SCAN) && (iss_q < rule_count_q);

  prf_rule_mem #(
    .Slots (RULE_SLOTS),
    .IdxW  (IdxW)
  ) u_rule_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (rule_count_q[IdxW-1:0]),
    .wr_data_i (wr_rule),
    .rd_en_i   (rd_en),
    .rd_idx_i  (iss_q[IdxW-1:0]),
    .rd_data_o (rd_rule)
  );

  prf_match u_match (
    .rule_i (rd_rule),
    .pkt_i  (pkt_q),
    .hit_o  (rule_hit)
  );

  always_comb begin
    state_d       = state_q;
    rule_count_d  = rule_count_q;
    iss_d         = iss_q;
    rd_vld_d      = rd_en;
    hit_d         = hit_q;
    verdict_d     = verdict_q;
    rej_d         = rej_q;
    pkt_d         = pkt_q;
    out_vld_d     = out_vld_q;
    out_verdict_d = out_verdict_q;
    out_rej_d     = out_rej_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pkt_d.src_address = wr_rule.src_address;
          pkt_d.dst_address = wr_rule.dst_address;
          pkt_d.src_l4port  = wr_rule.src_l4port;
          pkt_d.dst_l4port  = wr_rule.dst_l4port;
          pkt_d.deny_sel    = in_sel;
          iss_d             = '0;
          hit_d             = 1'b0;
          verdict_d         = 1'b0;
          rej_d             = 1'b0;
          if (act == ACT_INSERT) begin
            rej_d   = !wr_en;
            state_d = ST_DONE;
            if (wr_en) begin
              rule_count_d = rule_count_q + 1'b1;
            end
          end else if ((in_sel == DENY_NONE) || (rule_count_q == '0)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          iss_d = iss_q + 1'b1;
        end
        if (rd_vld_q && rule_hit) begin
          hit_d = 1'b1;
        end
        if (!rd_en && !rd_vld_q) begin
          verdict_d = hit_q;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d     = 1'b1;
          out_verdict_d = verdict_q;
          out_rej_d     = rej_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rule_count_q <= '0;
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      rule_count_q <= rule_count_d;
      rd_vld_q     <= rd_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q         <= iss_d;
    hit_q         <= hit_d;
    verdict_q     <= verdict_d;
    rej_q         <= rej_d;
    pkt_q         <= pkt_d;
    out_verdict_q <= out_verdict_d;
    out_rej_q     <= out_rej_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-2){1'b0}}, out_rej_q, out_verdict_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rule_count_q <= SlotsC)
    else $error("rule count above table size");

  a_write_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> rule_count_q == $past(rule_count_q) + 1'b1)
    else $error("rule write did not advance the count");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == ST_SCAN)
    else $error("rule read data outside a scan");

  a_resp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_DONE))
    else $error("response loaded outside the done state");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for packet_rule_filter_core. Insert and classify
// requests stream in with random gaps and random output stalls; a local
// deny-rule table tracks every accepted request and predicts each verdict
// and insert rejection, which is compared in order against the responses.
// ----------------------------------------------------------------------------
module tb;

  import prf_pkg::*;

  localparam int unsigned RULE_SLOTS   = 16;
  localparam int unsigned RANDOM_ITEMS = 1980;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_EVERY  = 500;
  localparam logic [ProtoW-1:0] PROTO_ICMP = 8'd1;
  localparam logic [DenyW-1:0]  DENY_BOTH  = DENY_TCP | DENY_UDP;

  typedef struct {
    action_e           act;
    logic [ProtoW-1:0] proto;
    logic [AddrW-1:0]  sa;
    logic [AddrW-1:0]  da;
    logic [PortW-1:0]  sp;
    logic [PortW-1:0]  dp;
    logic [AddrW-1:0]  sm;
    logic [AddrW-1:0]  dm;
    logic [DenyW-1:0]  deny;
    bit                drain;
  } filter_req_t;

  typedef struct {
    logic verdict;
    logic rejected;
  } filter_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // ip_protocol, source_address, dest_address, source_port, dest_port,
  // source_mask, dest_mask, deny_kind, zero fill
  logic [InDataW-1:0] s_axis_tdata = '0;
  // action
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // verdict, insert_rejected, zero fill
  logic [OutDataW-1:0] m_axis_tdata;

  filter_req_t  pending_q[$];
  filter_resp_t verdict_q[$];
  rule_t        gen_rules[$];
  filter_req_t  cur_req;

  rule_t       rule_tbl[RULE_SLOTS];
  int unsigned stored_rules = 0;

  int unsigned req_issued = 0;
  int unsigned req_accepted = 0;
  int unsigned resp_count = 0;
  int unsigned resp_handled = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned src_burst = 0;
  int unsigned sink_burst = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_count = 0;

  packet_rule_filter_core #(
    .RULE_SLOTS(RULE_SLOTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [InDataW-1:0] pack_request(filter_req_t r);
    return {6'b0, r.deny, r.dm, r.sm, r.dp, r.sp, r.da, r.sa, r.proto};
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 47) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [AddrW-1:0] draw_mask();
    int unsigned len;
    len = $urandom_range(0, 32);
    case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF;
      1: return 32'($urandom);
      default: return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endcase
  endfunction

  function automatic filter_resp_t predict_verdict(filter_req_t r);
    filter_resp_t     res;
    logic [DenyW-1:0] sel;
    rule_t            rl;
    res.verdict  = 1'b0;
    res.rejected = 1'b0;
    if (r.act == ACT_INSERT) begin
      if (stored_rules < RULE_SLOTS) begin
        rule_tbl[stored_rules] = '{deny_bits: r.deny, dst_l4port: r.dp, src_l4port: r.sp,
                                   dst_netmask: r.dm, dst_address: r.da,
                                   src_netmask: r.sm, src_address: r.sa};
        stored_rules++;
      end else begin
        res.rejected = 1'b1;
      end
    end else begin
      sel = (r.proto == PROTO_TCP) ? DENY_TCP :
            (r.proto == PROTO_UDP) ? DENY_UDP : DENY_NONE;
      if (sel != DENY_NONE) begin
        for (int unsigned k = 0; k < stored_rules; k++) begin
          rl = rule_tbl[k];
          if ((rl.deny_bits & sel) != DENY_NONE &&
              (r.da & rl.dst_netmask) == rl.dst_address &&
              (r.sa & rl.src_netmask) == rl.src_address &&
              (rl.dst_l4port == '0 || rl.dst_l4port == r.dp) &&
              (rl.src_l4port == '0 || rl.src_l4port == r.sp))
            res.verdict = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    $display("[%0t] mismatch on response %0d: %s got %0d expected %0d",
             $time, resp_count, what, got, exp_val);
    err_count++;
  endtask

  task automatic queue_insert(logic [ProtoW-1:0] proto, rule_t rl);
    filter_req_t r;
    r = '{act: ACT_INSERT, proto: proto, sa: rl.src_address, da: rl.dst_address,
          sp: rl.src_l4port, dp: rl.dst_l4port, sm: rl.src_netmask, dm: rl.dst_netmask,
          deny: rl.deny_bits, drain: 1'b0};
    pending_q.push_back(r);
    if (gen_rules.size() < RULE_SLOTS)
      gen_rules.push_back(rl);
  endtask

  task automatic queue_classify(logic [ProtoW-1:0] proto, logic [AddrW-1:0] sa,
                                logic [AddrW-1:0] da, logic [PortW-1:0] sp,
                                logic [PortW-1:0] dp);
    filter_req_t r;
    r = '{act: ACT_CLASSIFY, proto: proto, sa: sa, da: da, sp: sp, dp: dp,
          sm: 32'($urandom), dm: 32'($urandom), deny: 2'($urandom), drain: 1'b0};
    pending_q.push_back(r);
  endtask

  // request driver: present at the falling edge, hold until taken
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && req_accepted != req_issued)) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && verdict_q.size() != 0)) begin
        cur_req       <= pending_q[0];
        s_axis_tdata  <= pack_request(pending_q[0]);
        s_axis_tuser  <= pending_q[0].act;
        s_axis_tvalid <= 1'b1;
        void'(pending_q.pop_front());
        req_issued++;
        gap_left = draw_wait(src_burst);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // response sink: draw a random stall after each response taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (resp_count != resp_handled) begin
        resp_handled = resp_count;
        stall_left   = draw_wait(sink_burst);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  filter_resp_t exp_resp;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        resp_count  <= resp_count + 1;
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected response, tdata", 32'(m_axis_tdata), 0);
        end else begin
          exp_resp = verdict_q.pop_front();
          if (m_axis_tdata[0] !== exp_resp.verdict)
            report_mismatch("verdict", 32'(m_axis_tdata[0]), 32'(exp_resp.verdict));
          if (m_axis_tdata[1] !== exp_resp.rejected)
            report_mismatch("insert_rejected", 32'(m_axis_tdata[1]),
                            32'(exp_resp.rejected));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req_accepted <= req_accepted + 1;
        verdict_q.push_back(predict_verdict(cur_req));
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, idle_cycles);
        $display("** packet_rule_filter_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rule_t            rl;
    logic [ProtoW-1:0] proto;
    logic [AddrW-1:0] sa;
    logic [AddrW-1:0] da;
    logic [PortW-1:0] sp;
    logic [PortW-1:0] dp;
    int unsigned      pick;

    // empty table: nothing can drop
    queue_classify(PROTO_TCP, '0, '0, '0, '0);
    queue_classify(PROTO_UDP, '1, '1, '1, '1);
    // 10/8 source, any destination, any port, deny TCP
    queue_insert(8'hFF, '{deny_bits: DENY_TCP, dst_l4port: '0, src_l4port: '0,
                          dst_netmask: '0, dst_address: '0,
                          src_netmask: 32'hFF00_0000, src_address: 32'h0A00_0000});
    queue_classify(PROTO_TCP, 32'h0A12_3456, 32'h8081_8283, 16'h1234, 16'hF00D);
    queue_classify(PROTO_UDP, 32'h0A12_3456, 32'h8081_8283, 16'h1234, 16'hF00D);
    queue_classify(PROTO_ICMP, 32'h0A12_3456, 32'h8081_8283, 16'h1234, 16'hF00D);
    queue_classify(8'h00, 32'h0A12_3456, 32'h8081_8283, 16'h1234, 16'hF00D);
    queue_classify(8'hFF, 32'h0A12_3456, 32'h8081_8283, 16'h1234, 16'hF00D);
    // address bits outside the mask: never hits
    queue_insert(PROTO_TCP, '{deny_bits: DENY_BOTH, dst_l4port: '0, src_l4port: '0,
                              dst_netmask: '0, dst_address: '0,
                              src_netmask: '0, src_address: '1});
    queue_classify(PROTO_TCP, '1, '0, '0, '0);
    queue_classify(PROTO_UDP, '1, '0, '0, '0);
    // exact host pair and exact ports, deny UDP
    queue_insert(PROTO_UDP, '{deny_bits: DENY_UDP, dst_l4port: '1, src_l4port: '1,
                              dst_netmask: '1, dst_address: '1,
                              src_netmask: '1, src_address: '1});
    queue_classify(PROTO_UDP, '1, '1, '1, '1);
    queue_classify(PROTO_UDP, '1, '1, '1, 16'hFFFE);
    queue_classify(PROTO_UDP, '1, '1, 16'hFFFE, '1);
    queue_classify(PROTO_TCP, '1, '1, '1, '1);
    // exact source, destination prefix, destination port only
    queue_insert(8'h00, '{deny_bits: DENY_BOTH, dst_l4port: 16'd443, src_l4port: '0,
                          dst_netmask: 32'hFFFF_0000, dst_address: 32'hC0A8_0000,
                          src_netmask: '1, src_address: '0});
    queue_classify(PROTO_TCP, '0, 32'hC0A8_1234, 16'h4321, 16'd443);
    queue_classify(PROTO_UDP, '0, 32'hC0A8_1234, 16'h4321, 16'd443);
    queue_classify(PROTO_TCP, '0, 32'hC0A8_1234, 16'h4321, 16'd80);
    // catch-all rule with no deny bits
    queue_insert(PROTO_UDP, '{deny_bits: DENY_NONE, dst_l4port: '0, src_l4port: '0,
                              dst_netmask: '0, dst_address: '0,
                              src_netmask: '0, src_address: '0});
    queue_classify(PROTO_UDP, 32'h5555_AAAA, 32'hAAAA_5555, 16'h5A5A, 16'hA5A5);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        rl.src_netmask = draw_mask();
        rl.dst_netmask = draw_mask();
        rl.src_address = ($urandom_range(0, 5) == 0) ? 32'($urandom) :
                         (32'($urandom) & rl.src_netmask);
        rl.dst_address = ($urandom_range(0, 5) == 0) ? 32'($urandom) :
                         (32'($urandom) & rl.dst_netmask);
        rl.src_l4port  = $urandom_range(0, 1) ? '0 : 16'($urandom);
        rl.dst_l4port  = $urandom_range(0, 1) ? '0 : 16'($urandom);
        rl.deny_bits   = 2'($urandom);
        queue_insert(8'($urandom), rl);
      end else if (pick < 78 && gen_rules.size() != 0) begin
        // aim at a stored rule, then perturb now and again
        rl = gen_rules[$urandom_range(0, gen_rules.size() - 1)];
        sa = (rl.src_address & rl.src_netmask) | (32'($urandom) & ~rl.src_netmask);
        da = (rl.dst_address & rl.dst_netmask) | (32'($urandom) & ~rl.dst_netmask);
        sp = (rl.src_l4port != '0) ? rl.src_l4port : 16'($urandom);
        dp = (rl.dst_l4port != '0) ? rl.dst_l4port : 16'($urandom);
        case ($urandom_range(0, 11))
          0: sa[$urandom_range(0, 31)] = ~sa[$urandom_range(0, 31)];
          1: da[$urandom_range(0, 31)] = ~da[$urandom_range(0, 31)];
          2: sp = 16'($urandom);
          3: dp = 16'($urandom);
          default: ;
        endcase
        if ($urandom_range(0, 15) == 0)
          proto = PROTO_ICMP;
        else
          proto = $urandom_range(0, 1) ? PROTO_UDP : PROTO_TCP;
        queue_classify(proto, sa, da, sp, dp);
      end else begin
        case ($urandom_range(0, 3))
          0: proto = PROTO_TCP;
          1: proto = PROTO_UDP;
          2: proto = PROTO_ICMP;
          default: proto = 8'($urandom);
        endcase
        queue_classify(proto, 32'($urandom), 32'($urandom),
                       16'($urandom), 16'($urandom));
      end
      if (i % DRAIN_EVERY == 0)
        pending_q[pending_q.size() - 1].drain = 1'b1;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_q.size() == 0 && req_accepted == req_issued && verdict_q.size() == 0);
    repeat (40) @(posedge clk_i);

    if (err_count == 0)
      $display("** packet_rule_filter_core: PASSED **");
    else
      $display("** packet_rule_filter_core: FAILED **");
    $finish;
  end

endmodule
